// ----- sv/cpr_pkg.sv -----
// Shared types, widths and register codes for the clock page replacement block.
package cpr_pkg;

    localparam int FRAMES_DEF  = 64;
    localparam int ADDR_W      = 32;
    localparam int PAGE_W      = 30;
    localparam int OFS_W       = 5;
    localparam int NF_W        = 7;
    localparam int CFG_DATA_W  = 7;
    localparam int CFG_IDX_W   = 1;
    localparam int FRAME_OUT_W = 6;
    localparam int COUNT_W     = 32;

    localparam logic [OFS_W-1:0] OFS_MIN = 5'd2;
    localparam logic [OFS_W-1:0] OFS_MAX = 5'd20;
    localparam logic [OFS_W-1:0] OFS_RST = 5'd12;
    localparam logic [NF_W-1:0]  NF_RST  = 7'd64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_OFFSET = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_FRAMES  = 1'b1;

    // one frame table entry
    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic              ref_bit;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_MOD,
        ST_SWEEP,
        ST_DONE
    } state_t;

    // result fields handed from the engine to the output register
    typedef struct packed {
        logic               is_hit;
        logic               evicted_valid;
        logic [PAGE_W-1:0]  evicted_page;
        logic [COUNT_W-1:0] total_hits;
        logic [COUNT_W-1:0] total_misses;
    } result_t;

endpackage

// ----- sv/cpr_frame_mem.sv -----
// Frame table memory: one write port, one read port, registered read data.
module cpr_frame_mem #(
    parameter int FRAMES = cpr_pkg::FRAMES_DEF
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [(FRAMES > 1 ? $clog2(FRAMES) : 1)-1:0] wr_addr,
    input  cpr_pkg::entry_t                       wr_data,
    input  logic                                  rd_en,
    input  logic [(FRAMES > 1 ? $clog2(FRAMES) : 1)-1:0] rd_addr,
    output cpr_pkg::entry_t                       rd_data
);

    cpr_pkg::entry_t mem [FRAMES];
    cpr_pkg::entry_t rd_data_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/cpr_hand_mod.sv -----
// Iterative remainder of the clock hand by the frame count, one bit per cycle.
module cpr_hand_mod #(
    parameter int FRAMES = cpr_pkg::FRAMES_DEF,
    localparam int FIDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1,
    localparam int CNT_W  = $clog2(FRAMES + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [FIDX_W-1:0] dividend,
    input  logic [CNT_W-1:0]  divisor,
    output logic              busy,
    output logic [FIDX_W-1:0] rem
);

    localparam int SW = (FIDX_W > 1) ? $clog2(FIDX_W) : 1;
    localparam int WW = CNT_W + FIDX_W;

    logic              busy_reg, busy_next;
    logic [SW-1:0]     step_reg, step_next;
    logic [FIDX_W-1:0] rem_reg, rem_next;
    logic [WW-1:0]     shifted;
    logic [WW-1:0]     rem_wide;

    // restoring step: subtract divisor << step when it fits
    always_comb
    begin
        shifted   = WW'(divisor) << step_reg;
        rem_wide  = WW'(rem_reg);
        busy_next = busy_reg;
        step_next = step_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            rem_next  = dividend;
            step_next = SW'(FIDX_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_wide >= shifted)
            begin
                rem_next = FIDX_W'(rem_wide - shifted);
            end
            step_next = step_reg - SW'(1);
            busy_next = (step_reg != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
    end

    assign busy = busy_reg;
    assign rem  = rem_reg;

endmodule

// ----- sv/cpr_engine.sv -----
// Lookup, fill and clock sweep sequencer over the frame table memory.
module cpr_engine #(
    parameter int FRAMES = cpr_pkg::FRAMES_DEF,
    localparam int FIDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1,
    localparam int CNT_W  = $clog2(FRAMES + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [cpr_pkg::PAGE_W-1:0] page_in,
    input  logic [CNT_W-1:0]           n_in,
    output logic                       idle,
    output logic                       res_valid,
    input  logic                       res_take,
    output cpr_pkg::result_t           res,
    output logic [FIDX_W-1:0]          res_frame
);

    localparam logic [cpr_pkg::COUNT_W-1:0] COUNT_MAX = '1;

    function automatic logic [cpr_pkg::COUNT_W-1:0] sat_inc(
        input logic [cpr_pkg::COUNT_W-1:0] v
    );
        return (v == COUNT_MAX) ? v : v + cpr_pkg::COUNT_W'(1);
    endfunction

    cpr_pkg::state_t state_reg, state_next;

    logic [cpr_pkg::PAGE_W-1:0]  page_reg, page_next;
    logic [CNT_W-1:0]            n_reg, n_next;
    logic [CNT_W-1:0]            active_reg, active_next;
    logic [CNT_W-1:0]            issue_reg, issue_next;
    logic [CNT_W-1:0]            filled_reg, filled_next;
    logic                        chk_valid_reg, chk_valid_next;
    logic                        chk_first_reg, chk_first_next;
    logic [FIDX_W-1:0]           chk_idx_reg, chk_idx_next;
    logic [FIDX_W-1:0]           sw_idx_reg, sw_idx_next;
    logic [FIDX_W-1:0]           start_reg, start_next;
    logic [FIDX_W-1:0]           hand_reg, hand_next;
    logic [FIDX_W-1:0]           frame_reg, frame_next;
    logic [cpr_pkg::COUNT_W-1:0] hits_reg, hits_next;
    logic [cpr_pkg::COUNT_W-1:0] misses_reg, misses_next;
    logic                        is_hit_reg, is_hit_next;
    logic                        ref_fin_reg, ref_fin_next;
    logic                        ev_valid_reg, ev_valid_next;
    logic [cpr_pkg::PAGE_W-1:0]  ev_page_reg, ev_page_next;
    logic [cpr_pkg::PAGE_W-1:0]  first_page_reg, first_page_next;

    // memory and remainder unit controls
    logic              mem_wr_en, mem_rd_en;
    logic [FIDX_W-1:0] mem_wr_addr, mem_rd_addr;
    cpr_pkg::entry_t   mem_wr_data, mem_rd_data;
    logic              mod_start, mod_busy;
    logic [FIDX_W-1:0] mod_rem;

    logic match, look_end, found, sweep_end, has_free;

    cpr_frame_mem #(.FRAMES(FRAMES)) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    cpr_hand_mod #(.FRAMES(FRAMES)) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (hand_reg),
        .divisor  (n_reg),
        .busy     (mod_busy),
        .rem      (mod_rem)
    );

    // scan status
    assign match     = chk_valid_reg && (mem_rd_data.page == page_reg);
    assign look_end  = (issue_reg == active_reg);
    assign found     = chk_valid_reg && !mem_rd_data.ref_bit;
    assign sweep_end = (issue_reg == n_reg);
    assign has_free  = (filled_reg < n_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cpr_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = cpr_pkg::ST_LOOK;
                end
            end
            cpr_pkg::ST_LOOK:
            begin
                if (match)
                begin
                    state_next = cpr_pkg::ST_DONE;
                end
                else if (look_end)
                begin
                    state_next = has_free ? cpr_pkg::ST_DONE : cpr_pkg::ST_MOD;
                end
            end
            cpr_pkg::ST_MOD:
            begin
                if (!mod_busy)
                begin
                    state_next = cpr_pkg::ST_SWEEP;
                end
            end
            cpr_pkg::ST_SWEEP:
            begin
                if (found || sweep_end)
                begin
                    state_next = cpr_pkg::ST_DONE;
                end
            end
            cpr_pkg::ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = cpr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cpr_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and memory accesses
    always_comb
    begin
        logic [FIDX_W-1:0]          victim;
        logic [cpr_pkg::PAGE_W-1:0] evp;

        victim          = start_reg;
        evp             = first_page_reg;
        page_next       = page_reg;
        n_next          = n_reg;
        active_next     = active_reg;
        issue_next      = issue_reg;
        filled_next     = filled_reg;
        chk_valid_next  = chk_valid_reg;
        chk_first_next  = chk_first_reg;
        chk_idx_next    = chk_idx_reg;
        sw_idx_next     = sw_idx_reg;
        start_next      = start_reg;
        hand_next       = hand_reg;
        frame_next      = frame_reg;
        hits_next       = hits_reg;
        misses_next     = misses_reg;
        is_hit_next     = is_hit_reg;
        ref_fin_next    = ref_fin_reg;
        ev_valid_next   = ev_valid_reg;
        ev_page_next    = ev_page_reg;
        first_page_next = first_page_reg;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = frame_reg;
        mem_wr_data     = '{page: page_reg, ref_bit: ref_fin_reg};
        mem_rd_en       = 1'b0;
        mem_rd_addr     = sw_idx_reg;
        mod_start       = 1'b0;

        case (state_reg)
            cpr_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    page_next      = page_in;
                    n_next         = n_in;
                    active_next    = (filled_reg < n_in) ? filled_reg : n_in;
                    issue_next     = '0;
                    chk_valid_next = 1'b0;
                end
            end
            cpr_pkg::ST_LOOK:
            begin
                // one read per cycle over the filled frames within the frame count
                chk_valid_next = 1'b0;
                if (!look_end)
                begin
                    mem_rd_en      = 1'b1;
                    mem_rd_addr    = issue_reg[FIDX_W-1:0];
                    chk_idx_next   = issue_reg[FIDX_W-1:0];
                    chk_valid_next = 1'b1;
                    issue_next     = issue_reg + CNT_W'(1);
                end
                if (match)
                begin
                    is_hit_next   = 1'b1;
                    frame_next    = chk_idx_reg;
                    ref_fin_next  = 1'b1;
                    ev_valid_next = 1'b0;
                    ev_page_next  = '0;
                    hits_next     = sat_inc(hits_reg);
                end
                else if (look_end)
                begin
                    is_hit_next   = 1'b0;
                    ref_fin_next  = 1'b0;
                    misses_next   = sat_inc(misses_reg);
                    ev_valid_next = 1'b0;
                    ev_page_next  = '0;
                    if (has_free)
                    begin
                        frame_next  = filled_reg[FIDX_W-1:0];
                        filled_next = filled_reg + CNT_W'(1);
                    end
                    else
                    begin
                        mod_start = 1'b1;
                    end
                end
            end
            cpr_pkg::ST_MOD:
            begin
                issue_next     = '0;
                chk_valid_next = 1'b0;
                sw_idx_next    = mod_rem;
                start_next     = mod_rem;
            end
            cpr_pkg::ST_SWEEP:
            begin
                // issue the next frame of the sweep
                chk_valid_next = 1'b0;
                if (!sweep_end)
                begin
                    mem_rd_en      = 1'b1;
                    mem_rd_addr    = sw_idx_reg;
                    chk_idx_next   = sw_idx_reg;
                    chk_first_next = (issue_reg == '0);
                    chk_valid_next = 1'b1;
                    issue_next     = issue_reg + CNT_W'(1);
                    sw_idx_next    = ((CNT_W'(sw_idx_reg) + CNT_W'(1)) == n_reg)
                                     ? '0 : sw_idx_reg + FIDX_W'(1);
                end
                if (chk_valid_reg && chk_first_reg)
                begin
                    first_page_next = mem_rd_data.page;
                end
                // second chance: clear a set reference bit
                if (chk_valid_reg && mem_rd_data.ref_bit)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = chk_idx_reg;
                    mem_wr_data = '{page: mem_rd_data.page, ref_bit: 1'b0};
                end
                if (found)
                begin
                    victim = chk_idx_reg;
                    evp    = mem_rd_data.page;
                end
                else if (chk_valid_reg && chk_first_reg)
                begin
                    evp = mem_rd_data.page;
                end
                if (found || sweep_end)
                begin
                    frame_next    = victim;
                    ev_valid_next = 1'b1;
                    ev_page_next  = evp;
                    hand_next     = ((CNT_W'(victim) + CNT_W'(1)) == n_reg)
                                    ? '0 : victim + FIDX_W'(1);
                end
            end
            cpr_pkg::ST_DONE:
            begin
                // install the page, or set the reference bit on a hit
                mem_wr_en = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cpr_pkg::ST_IDLE;
            filled_reg    <= '0;
            hand_reg      <= '0;
            hits_reg      <= '0;
            misses_reg    <= '0;
            issue_reg     <= '0;
            active_reg    <= '0;
            n_reg         <= CNT_W'(1);
            chk_valid_reg <= 1'b0;
            chk_first_reg <= 1'b0;
            sw_idx_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            filled_reg    <= filled_next;
            hand_reg      <= hand_next;
            hits_reg      <= hits_next;
            misses_reg    <= misses_next;
            issue_reg     <= issue_next;
            active_reg    <= active_next;
            n_reg         <= n_next;
            chk_valid_reg <= chk_valid_next;
            chk_first_reg <= chk_first_next;
            sw_idx_reg    <= sw_idx_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        page_reg       <= page_next;
        chk_idx_reg    <= chk_idx_next;
        start_reg      <= start_next;
        frame_reg      <= frame_next;
        is_hit_reg     <= is_hit_next;
        ref_fin_reg    <= ref_fin_next;
        ev_valid_reg   <= ev_valid_next;
        ev_page_reg    <= ev_page_next;
        first_page_reg <= first_page_next;
    end

    assign idle      = (state_reg == cpr_pkg::ST_IDLE);
    assign res_valid = (state_reg == cpr_pkg::ST_DONE);
    assign res_frame = frame_reg;
    assign res       = '{is_hit:        is_hit_reg,
                         evicted_valid: ev_valid_reg,
                         evicted_page:  ev_page_reg,
                         total_hits:    hits_reg,
                         total_misses:  misses_reg};

    // a sweep write never lands on the entry being read
    a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_rd_en && mem_wr_en) |-> (mem_rd_addr != mem_wr_addr))
        else $error("frame table read and write hit the same entry");

    a_look_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cpr_pkg::ST_LOOK) |-> (issue_reg <= active_reg))
        else $error("lookup ran past the filled frames");

    a_sweep_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cpr_pkg::ST_SWEEP) |-> (CNT_W'(sw_idx_reg) < n_reg))
        else $error("sweep index outside the frame count");

    a_filled_max: assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg <= CNT_W'(FRAMES))
        else $error("fill count above built frame count");

endmodule

// ----- sv/clock_page_replacement_core.sv -----
// Top level: config registers, page number extraction, engine and output register.
//
//  channel   direction  handshake             payload
//  in        input      in_valid / in_ready   address
//  out       output     out_valid / out_ready is_hit, frame_used, evicted_valid,
//                                             evicted_page, total_hits, total_misses
//  cfg       input      cfg_we                cfg_index, cfg_data
//
// One beat at a time. A hit or fill probes A frames, where A is at most the
// filled count; an eviction also computes the hand remainder and then sweeps
// N frames, N being the number of frames swept (at most the frame count).
// The lookup and the clock sweep each read one frame table entry per cycle
// through the single read port.
// No clearing pass after reset: only frames already filled are ever read.
// in_ready is high only between beats; a finished result sits in the output
// register, so a new beat can be taken while the previous one waits on out_ready.
module clock_page_replacement_core #(
    parameter int FRAMES = cpr_pkg::FRAMES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [cpr_pkg::ADDR_W-1:0]      address,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            is_hit,
    output logic [cpr_pkg::FRAME_OUT_W-1:0] frame_used,
    output logic                            evicted_valid,
    output logic [cpr_pkg::PAGE_W-1:0]      evicted_page,
    output logic [cpr_pkg::COUNT_W-1:0]     total_hits,
    output logic [cpr_pkg::COUNT_W-1:0]     total_misses,
    input  logic                            cfg_we,
    input  logic [cpr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cpr_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int FIDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W  = $clog2(FRAMES + 1);
    localparam int NW     = (CNT_W > cpr_pkg::NF_W) ? CNT_W : cpr_pkg::NF_W;

    logic [cpr_pkg::OFS_W-1:0] ofs_reg;
    logic [cpr_pkg::NF_W-1:0]  nframes_reg;
    logic [cpr_pkg::OFS_W-1:0] ofs_eff;
    logic [NW-1:0]             nf_wide;
    logic [CNT_W-1:0]          n_eff;
    logic [cpr_pkg::PAGE_W-1:0] page;

    logic                      start;
    logic                      eng_idle;
    logic                      res_valid;
    logic                      res_take;
    cpr_pkg::result_t          res;
    logic [FIDX_W-1:0]         res_frame;
    logic [FIDX_W+cpr_pkg::FRAME_OUT_W-1:0] frame_ext;

    logic                       out_valid_reg, out_valid_next;
    cpr_pkg::result_t           out_res_reg;
    logic [cpr_pkg::FRAME_OUT_W-1:0] frame_used_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ofs_reg     <= cpr_pkg::OFS_RST;
            nframes_reg <= cpr_pkg::NF_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cpr_pkg::CFG_PAGE_OFFSET: ofs_reg     <= cfg_data[cpr_pkg::OFS_W-1:0];
                cpr_pkg::CFG_NUM_FRAMES:  nframes_reg <= cfg_data[cpr_pkg::NF_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // clamp config to legal ranges, form the page number
    always_comb
    begin
        if (ofs_reg < cpr_pkg::OFS_MIN)
        begin
            ofs_eff = cpr_pkg::OFS_MIN;
        end
        else if (ofs_reg > cpr_pkg::OFS_MAX)
        begin
            ofs_eff = cpr_pkg::OFS_MAX;
        end
        else
        begin
            ofs_eff = ofs_reg;
        end
        nf_wide = NW'(nframes_reg);
        if (nf_wide == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (nf_wide > NW'(FRAMES))
        begin
            n_eff = CNT_W'(FRAMES);
        end
        else
        begin
            n_eff = CNT_W'(nf_wide);
        end
        page = cpr_pkg::PAGE_W'(address >> ofs_eff);
    end

    assign in_ready = eng_idle;
    assign start    = in_valid && eng_idle;

    cpr_engine #(.FRAMES(FRAMES)) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .page_in   (page),
        .n_in      (n_eff),
        .idle      (eng_idle),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res),
        .res_frame (res_frame)
    );

    // output register
    assign res_take       = res_valid && (!out_valid_reg || out_ready);
    assign out_valid_next = res_take || (out_valid_reg && !out_ready);
    assign frame_ext      = {{cpr_pkg::FRAME_OUT_W{1'b0}}, res_frame};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_res_reg    <= res;
            frame_used_reg <= frame_ext[cpr_pkg::FRAME_OUT_W-1:0];
        end
    end

    assign out_valid     = out_valid_reg;
    assign is_hit        = out_res_reg.is_hit;
    assign frame_used    = frame_used_reg;
    assign evicted_valid = out_res_reg.evicted_valid;
    assign evicted_page  = out_res_reg.evicted_page;
    assign total_hits    = out_res_reg.total_hits;
    assign total_misses  = out_res_reg.total_misses;

endmodule

// ----- bench/clock_page_replacement_checker.sv -----
// Checker: watches the ports, models the frame table and compares every result.
module clock_page_replacement_checker #(
    parameter int FRAMES = cpr_pkg::FRAMES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic [cpr_pkg::ADDR_W-1:0]      address,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic                            is_hit,
    input  logic [cpr_pkg::FRAME_OUT_W-1:0] frame_used,
    input  logic                            evicted_valid,
    input  logic [cpr_pkg::PAGE_W-1:0]      evicted_page,
    input  logic [cpr_pkg::COUNT_W-1:0]     total_hits,
    input  logic [cpr_pkg::COUNT_W-1:0]     total_misses,
    input  logic                            cfg_we,
    input  logic [cpr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cpr_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              outstanding,
    output int                              errors,
    output int                              checked,
    output int                              hits_seen,
    output int                              evictions_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    // what one access should report
    typedef struct packed {
        logic                            is_hit;
        logic [cpr_pkg::FRAME_OUT_W-1:0] frame;
        logic                            ev_valid;
        logic [cpr_pkg::PAGE_W-1:0]      ev_page;
        logic [cpr_pkg::COUNT_W-1:0]     hits;
        logic [cpr_pkg::COUNT_W-1:0]     misses;
    } access_result_t;

    // model of the frame table and counters
    logic [cpr_pkg::PAGE_W-1:0]  resident_page [0:FRAMES-1];
    logic                        ref_flag      [0:FRAMES-1];
    int unsigned                 hand;
    int unsigned                 filled;
    logic [cpr_pkg::COUNT_W-1:0] hit_total;
    logic [cpr_pkg::COUNT_W-1:0] miss_total;
    logic [cpr_pkg::OFS_W-1:0]   offset_cfg;
    logic [cpr_pkg::NF_W-1:0]    frames_cfg;

    access_result_t     pending_results [$];
    access_result_t     want;
    int                 fail_count;
    int                 checked_count;
    int                 hit_count;
    int                 evict_count;

    function automatic logic [cpr_pkg::COUNT_W-1:0] sat_bump(
        input logic [cpr_pkg::COUNT_W-1:0] v
    );
        return (v == '1) ? v : v + cpr_pkg::COUNT_W'(1);
    endfunction

    // second-chance lookup and replacement for one access; updates the model
    function automatic access_result_t resolve_access(
        input logic [cpr_pkg::ADDR_W-1:0] addr
    );
        int unsigned                shift;
        int unsigned                n;
        int unsigned                active;
        int unsigned                start;
        int unsigned                idx;
        int unsigned                slot;
        int unsigned                i;
        logic [cpr_pkg::PAGE_W-1:0] page;
        logic                       found;
        logic                       chosen;
        access_result_t             r;

        shift = offset_cfg;
        if (shift < cpr_pkg::OFS_MIN) shift = cpr_pkg::OFS_MIN;
        if (shift > cpr_pkg::OFS_MAX) shift = cpr_pkg::OFS_MAX;
        n = frames_cfg;
        if (n < 1) n = 1;
        if (n > FRAMES) n = FRAMES;

        page   = cpr_pkg::PAGE_W'(addr >> shift);
        active = (filled < n) ? filled : n;
        r      = '0;
        found  = 1'b0;
        slot   = 0;

        // lowest matching frame wins when a page sits in two frames
        for (i = 0; i < active; i++)
        begin
            if (!found && resident_page[i] == page)
            begin
                found = 1'b1;
                slot  = i;
            end
        end

        if (found)
        begin
            ref_flag[slot] = 1'b1;
            hit_total      = sat_bump(hit_total);
            r.is_hit       = 1'b1;
        end
        else
        begin
            miss_total = sat_bump(miss_total);
            if (filled < n)
            begin
                slot   = filled;
                filled = filled + 1;
            end
            else
            begin
                // sweep from the hand, giving referenced frames a second chance
                start  = hand % n;
                chosen = 1'b0;
                for (i = 0; i < n; i++)
                begin
                    idx = (start + i) % n;
                    if (!chosen)
                    begin
                        if (ref_flag[idx])
                            ref_flag[idx] = 1'b0;
                        else
                        begin
                            slot   = idx;
                            chosen = 1'b1;
                        end
                    end
                end
                if (!chosen)
                    slot = start;
                hand       = (slot + 1) % n;
                r.ev_valid = 1'b1;
                r.ev_page  = resident_page[slot];
            end
            resident_page[slot] = page;
            ref_flag[slot]      = 1'b0;
        end

        r.frame  = cpr_pkg::FRAME_OUT_W'(slot);
        r.hits   = hit_total;
        r.misses = miss_total;
        return r;
    endfunction

    function automatic void check_field(input string name,
                                        input logic [cpr_pkg::COUNT_W-1:0] exp_v,
                                        input logic [cpr_pkg::COUNT_W-1:0] got_v);
        if (exp_v !== got_v)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, exp_v, got_v);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < FRAMES; k++)
            begin
                resident_page[k] = '0;
                ref_flag[k]      = 1'b0;
            end
            hand          = 0;
            filled        = 0;
            hit_total     = '0;
            miss_total    = '0;
            offset_cfg    = cpr_pkg::OFS_RST;
            frames_cfg    = cpr_pkg::NF_RST;
            fail_count    = 0;
            checked_count = 0;
            hit_count     = 0;
            evict_count   = 0;
            pending_results.delete();
            outstanding    <= 0;
            errors         <= 0;
            checked        <= 0;
            hits_seen      <= 0;
            evictions_seen <= 0;
        end
        else
        begin
            // result beat: compare with the oldest prediction
            if (out_valid === 1'b1 && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result with nothing outstanding: hit=%0b frame=%0d",
                             $time, is_hit, frame_used);
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("is_hit", cpr_pkg::COUNT_W'(want.is_hit),
                                cpr_pkg::COUNT_W'(is_hit));
                    check_field("frame_used", cpr_pkg::COUNT_W'(want.frame),
                                cpr_pkg::COUNT_W'(frame_used));
                    check_field("evicted_valid", cpr_pkg::COUNT_W'(want.ev_valid),
                                cpr_pkg::COUNT_W'(evicted_valid));
                    check_field("evicted_page", cpr_pkg::COUNT_W'(want.ev_page),
                                cpr_pkg::COUNT_W'(evicted_page));
                    check_field("total_hits", want.hits, total_hits);
                    check_field("total_misses", want.misses, total_misses);
                    checked_count++;
                    if (want.is_hit)
                        hit_count++;
                    if (want.ev_valid)
                        evict_count++;
                end
            end

            // access beat: predict its result
            if (in_valid && in_ready === 1'b1)
                pending_results.push_back(resolve_access(address));

            // register writes
            if (cfg_we)
            begin
                if (cfg_index == cpr_pkg::CFG_PAGE_OFFSET)
                    offset_cfg = cfg_data[cpr_pkg::OFS_W-1:0];
                else if (cfg_index == cpr_pkg::CFG_NUM_FRAMES)
                    frames_cfg = cfg_data[cpr_pkg::NF_W-1:0];
            end

            outstanding    <= pending_results.size();
            errors         <= fail_count;
            checked        <= checked_count;
            hits_seen      <= hit_count;
            evictions_seen <= evict_count;
        end
    end

endmodule

// ----- bench/clock_page_replacement_core_test.sv -----
// Testbench top: clock, reset, access stimulus, result back-pressure, watchdog and verdict.
module clock_page_replacement_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD     = 6;
    localparam int RESET_CYCLES    = 6;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 198;
    localparam int POOL_DEPTH      = 96;
    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 8;
    localparam int TAIL_CYCLES     = 200;
    localparam int WATCHDOG_LIMIT  = 5000;

    logic                                clk           = 1'b0;
    logic                                rst_n         = 1'b0;
    logic                                in_valid      = 1'b0;
    logic                                in_ready;
    logic [cpr_pkg::ADDR_W-1:0]          address       = '0;
    logic                                out_valid;
    logic                                out_ready     = 1'b0;
    logic                                is_hit;
    logic [cpr_pkg::FRAME_OUT_W-1:0]     frame_used;
    logic                                evicted_valid;
    logic [cpr_pkg::PAGE_W-1:0]          evicted_page;
    logic [cpr_pkg::COUNT_W-1:0]         total_hits;
    logic [cpr_pkg::COUNT_W-1:0]         total_misses;
    logic                                cfg_we        = 1'b0;
    logic [cpr_pkg::CFG_IDX_W-1:0]       cfg_index     = '0;
    logic [cpr_pkg::CFG_DATA_W-1:0]      cfg_data      = '0;

    int   outstanding;
    int   errors;
    int   checked;
    int   hits_seen;
    int   evictions_seen;
    int   sent          = 0;
    int   send_idle_pct = 9;
    int   recv_idle_pct = 60;
    int   idle_cycles   = 0;
    int   hold_reqs     = 0;
    int   holds_done    = 0;

    clock_page_replacement_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .address       (address),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .is_hit        (is_hit),
        .frame_used    (frame_used),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .total_hits    (total_hits),
        .total_misses  (total_misses),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    clock_page_replacement_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .address        (address),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .is_hit         (is_hit),
        .frame_used     (frame_used),
        .evicted_valid  (evicted_valid),
        .evicted_page   (evicted_page),
        .total_hits     (total_hits),
        .total_misses   (total_misses),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .outstanding    (outstanding),
        .errors         (errors),
        .checked        (checked),
        .hits_seen      (hits_seen),
        .evictions_seen (evictions_seen)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // result side: random back-pressure, or one long hold-off per request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (holds_done != hold_reqs)
            begin
                out_ready  <= 1'b0;
                holds_done  = hold_reqs;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog: too long without any beat on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("[clock_page_replacement_core] ERROR");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // offer one access and wait for its beat; valid stays high if no gap follows
    task automatic send_access(input logic [cpr_pkg::ADDR_W-1:0] addr);
        // idling: sender light and receiver heavy, then swapped, then none
        if (sent < 667)
        begin
            send_idle_pct = 9;
            recv_idle_pct = 60;
        end
        else if (sent < 1334)
        begin
            send_idle_pct = 60;
            recv_idle_pct = 9;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        address  <= addr;
        do @(posedge clk); while (in_ready !== 1'b1);
        sent++;
    endtask

    // pause the sender until every predicted result has come back
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write both registers on consecutive cycles; block must be idle
    task automatic configure(input logic [cpr_pkg::CFG_DATA_W-1:0] ofs_data,
                             input logic [cpr_pkg::CFG_DATA_W-1:0] nf_data);
        cfg_we    <= 1'b1;
        cfg_index <= cpr_pkg::CFG_PAGE_OFFSET;
        cfg_data  <= ofs_data;
        @(posedge clk);
        cfg_index <= cpr_pkg::CFG_NUM_FRAMES;
        cfg_data  <= nf_data;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [cpr_pkg::ADDR_W-1:0]     base_pool [0:POOL_DEPTH-1];
        logic [cpr_pkg::ADDR_W-1:0]     mask;
        logic [cpr_pkg::ADDR_W-1:0]     base;
        logic [cpr_pkg::CFG_DATA_W-1:0] ofs_data;
        logic [cpr_pkg::CFG_DATA_W-1:0] nf_data;
        int unsigned                    shift;
        int unsigned                    nf_eff;
        int unsigned                    span;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset mapping: address extremes, a same-page hit
        send_access(32'h0000_0000);
        send_access(32'hFFFF_FFFF);
        send_access(32'h0000_0FFF);
        send_access(32'h8000_0000);
        send_access(32'h5555_5555);

        // frame count lowered below the fill level: hidden frames miss
        drain();
        configure(7'd12, 7'd2);
        send_access(32'h8000_0000);
        send_access(32'h0000_0ABC);

        // count raised again: a page now held twice hits its lowest frame
        drain();
        configure(7'd12, 7'd64);
        send_access(32'h8000_0123);
        send_access(32'hAAAA_AAAA);

        // offset below range, zero frames: sweep over an all-referenced table
        drain();
        configure(7'd1, 7'd0);
        send_access(32'h0000_0004);
        send_access(32'hFFFF_FFFC);
        send_access(32'hFFFF_FFFF);

        // offset above range with upper data bits set, frame count above range
        drain();
        configure(7'h7F, 7'd127);
        send_access(32'hFFF0_0000);
        send_access(32'h000F_FFFF);
        send_access(32'h0000_0000);

        // smallest page size
        drain();
        configure(7'd2, 7'd64);
        send_access(32'h0000_0003);
        send_access(32'h7FFF_FFFF);

        for (int p = 0; p < POOL_DEPTH; p++)
            base_pool[p] = $urandom;

        // random phases: a working set of pages per setting, plus stray accesses
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    ofs_data = 7'd12;
                    nf_data  = 7'd64;
                end
                1:
                begin
                    ofs_data = 7'd2;
                    nf_data  = 7'd8;
                end
                2:
                begin
                    ofs_data = 7'd20;
                    nf_data  = 7'd64;
                end
                3:
                begin
                    ofs_data = 7'd1;
                    nf_data  = 7'd0;
                end
                4:
                begin
                    ofs_data = 7'd31;
                    nf_data  = 7'd127;
                end
                5:
                begin
                    ofs_data = 7'd12;
                    nf_data  = 7'd64;
                end
                6:
                begin
                    ofs_data = 7'd12;
                    nf_data  = 7'd5;
                end
                7:
                begin
                    ofs_data = 7'd12;
                    nf_data  = 7'd64;
                end
                default:
                begin
                    ofs_data = cpr_pkg::CFG_DATA_W'($urandom_range(0, 31));
                    nf_data  = cpr_pkg::CFG_DATA_W'($urandom_range(0, 127));
                end
            endcase
            drain();
            configure(ofs_data, nf_data);

            shift = ofs_data[cpr_pkg::OFS_W-1:0];
            if (shift < cpr_pkg::OFS_MIN) shift = cpr_pkg::OFS_MIN;
            if (shift > cpr_pkg::OFS_MAX) shift = cpr_pkg::OFS_MAX;
            nf_eff = nf_data;
            if (nf_eff < 1) nf_eff = 1;
            if (nf_eff > cpr_pkg::FRAMES_DEF) nf_eff = cpr_pkg::FRAMES_DEF;
            mask = (32'h1 << shift) - 32'h1;

            // working set at least as large as the frames in use: hits and evictions
            span = nf_eff + $urandom_range(0, nf_eff / 2 + 1);
            if (span > POOL_DEPTH) span = POOL_DEPTH;
            for (int p = 0; p < POOL_DEPTH; p++)
                if ($urandom_range(99) < 30)
                    base_pool[p] = $urandom;

            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                // long output stall while accesses keep coming
                if (ph == 2 && k == 60)
                    hold_reqs <= hold_reqs + 1;
                if ($urandom_range(99) < 85)
                begin
                    base = base_pool[$urandom_range(0, span - 1)];
                    send_access((base & ~mask) | ($urandom & mask));
                end
                else
                    send_access($urandom);
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Checked %0d accesses: %0d hits, %0d evictions.",
                 checked, hits_seen, evictions_seen);
        $display("Offsets 0..31 and frame counts 0..127, lowered and raised, with a long output stall.");
        if (errors == 0)
            $display("[clock_page_replacement_core] OK");
        else
            $display("[clock_page_replacement_core] ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/cpr_pkg.sv
sv/cpr_frame_mem.sv
sv/cpr_hand_mod.sv
sv/cpr_engine.sv
sv/clock_page_replacement_core.sv
bench/clock_page_replacement_checker.sv
bench/clock_page_replacement_core_test.sv
